// ===== rtl/pctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, codes and helpers for the prefix code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int SYMBOL_COUNT_DEFAULT = 256;
    localparam int MAX_CODE_LEN         = 16;
    localparam int CODE_W               = 16;
    localparam int LEN_W                = 5;
    localparam int SYM_W                = 8;
    localparam int CODE_LIMIT           = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int GROUP_SIZE           = 16;
    localparam int GROUP_IDX_W          = 4;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_BIT  = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TRUNC    = 2'd1;
    localparam logic [1:0] STATUS_OVERLONG = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_GROUP,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [SYM_W-1:0]  entry_symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
        logic              coded_bit;
    } in_t;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic [1:0]       status;
    } out_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } probe_t;

    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int k = 0; k < CODE_W; k++)
        begin
            m[k] = (len > LEN_W'(k));
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pctd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_cell
// One table entry: holds a code and its length, flags a match each cycle.
// ----------------------------------------------------------------------------
module pctd_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [pctd_pkg::CODE_W-1:0]   wr_code,
    input  wire logic [pctd_pkg::LEN_W-1:0]    wr_length,
    input  wire pctd_pkg::probe_t              probe,
    output logic                               match
);

    logic [pctd_pkg::CODE_W-1:0] code_reg;
    logic [pctd_pkg::LEN_W-1:0]  length_reg;
    logic                        match_reg;
    logic                        match_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_reg <= wr_code & pctd_pkg::code_mask(wr_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (wr_en)
        begin
            length_reg <= wr_length;
        end
    end

    assign match_next = (length_reg != '0) && (length_reg == probe.length)
                        && (code_reg == probe.code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule
`default_nettype wire

// ===== rtl/pctd_group.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_group
// Registered priority encoder over one group of cell match flags.
// ----------------------------------------------------------------------------
module pctd_group (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pctd_pkg::GROUP_SIZE-1:0]   match,
    output logic                                   found,
    output logic [pctd_pkg::GROUP_IDX_W-1:0]       index
);

    logic                               found_reg;
    logic                               found_next;
    logic [pctd_pkg::GROUP_IDX_W-1:0]   index_reg;
    logic [pctd_pkg::GROUP_IDX_W-1:0]   index_next;

    always_comb
    begin
        found_next = |match;
        index_next = '0;
        for (int k = pctd_pkg::GROUP_SIZE - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                index_next = pctd_pkg::GROUP_IDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
    end

    assign found = found_reg;
    assign index = index_reg;

endmodule
`default_nettype wire

// ===== rtl/prefix_code_table_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_table_decoder_core
// Prefix code decoder: a row of table cells compares the running code each
// cycle, grouped priority encoders pick the lowest matching symbol.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     in_data  (func, entry fields, coded bit)
//   out       out_valid / out_ready   out_data (decoded_symbol, status)
//
// A coded bit goes through transfer, cell compare, group encode, final pick,
// taking no new item meanwhile. Loads, ends, unused codes finish at transfer.
// Reset clears every entry length, so all entries start invalid at once.
// A result waits in the output register; a new item is taken once it drains.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder_core #(
    parameter int SYMBOL_COUNT = pctd_pkg::SYMBOL_COUNT_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pctd_pkg::in_t      in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pctd_pkg::out_t          out_data
);

    localparam int NG = (SYMBOL_COUNT + pctd_pkg::GROUP_SIZE - 1) / pctd_pkg::GROUP_SIZE;

    pctd_pkg::state_t               state_reg;
    pctd_pkg::state_t               state_next;
    logic [pctd_pkg::CODE_W-1:0]    pending_code_reg;
    logic [pctd_pkg::CODE_W-1:0]    pending_code_next;
    logic [pctd_pkg::LEN_W-1:0]     pending_len_reg;
    logic [pctd_pkg::LEN_W-1:0]     pending_len_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    pctd_pkg::out_t                 out_data_reg;
    pctd_pkg::out_t                 out_data_next;

    logic                           in_fire;
    logic                           load_fire;
    pctd_pkg::probe_t               probe;
    logic [NG*pctd_pkg::GROUP_SIZE-1:0] match_vec;
    logic [NG-1:0]                  grp_found;
    logic [pctd_pkg::GROUP_IDX_W-1:0] grp_idx [NG];
    logic                           pick_found;
    logic [pctd_pkg::SYM_W-1:0]     pick_sym;

    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (in_data.func == pctd_pkg::FUNC_LOAD);

    assign probe.code   = pending_code_reg;
    assign probe.length = pending_len_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NG * pctd_pkg::GROUP_SIZE; gi++)
        begin : g_cell
            if (gi < SYMBOL_COUNT)
            begin : g_live
                pctd_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .wr_en     (load_fire
                                && (in_data.entry_symbol == pctd_pkg::SYM_W'(gi))),
                    .wr_code   (in_data.entry_code),
                    .wr_length (in_data.entry_length),
                    .probe     (probe),
                    .match     (match_vec[gi])
                );
            end
            else
            begin : g_pad
                assign match_vec[gi] = 1'b0;
            end
        end

        for (gi = 0; gi < NG; gi++)
        begin : g_grp
            pctd_group u_group (
                .clk   (clk),
                .rst_n (rst_n),
                .match (match_vec[gi*pctd_pkg::GROUP_SIZE +: pctd_pkg::GROUP_SIZE]),
                .found (grp_found[gi]),
                .index (grp_idx[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pick_found = 1'b0;
        pick_sym   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_found[g])
            begin
                pick_found = 1'b1;
                pick_sym   = pctd_pkg::SYM_W'(g * pctd_pkg::GROUP_SIZE)
                             + pctd_pkg::SYM_W'(grp_idx[g]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pctd_pkg::ST_IDLE;
            pending_code_reg <= '0;
            pending_len_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pending_code_reg <= pending_code_next;
            pending_len_reg  <= pending_len_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        pending_code_next = pending_code_reg;
        pending_len_next  = pending_len_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;
        in_ready          = 1'b0;

        unique case (state_reg)
            pctd_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    if (in_data.func == pctd_pkg::FUNC_BIT)
                    begin
                        pending_code_next = {pending_code_reg[pctd_pkg::CODE_W-2:0],
                                             in_data.coded_bit};
                        pending_len_next  = pending_len_reg + 1'b1;
                        state_next        = pctd_pkg::ST_MATCH;
                    end
                    else if ((in_data.func == pctd_pkg::FUNC_END)
                             && (pending_len_reg != '0))
                    begin
                        pending_code_next            = '0;
                        pending_len_next             = '0;
                        out_valid_next               = 1'b1;
                        out_data_next.decoded_symbol = '0;
                        out_data_next.status         = pctd_pkg::STATUS_TRUNC;
                    end
                end
            end
            pctd_pkg::ST_MATCH:
            begin
                state_next = pctd_pkg::ST_GROUP;
            end
            pctd_pkg::ST_GROUP:
            begin
                state_next = pctd_pkg::ST_PICK;
            end
            pctd_pkg::ST_PICK:
            begin
                state_next = pctd_pkg::ST_IDLE;
                if (pick_found)
                begin
                    pending_code_next            = '0;
                    pending_len_next             = '0;
                    out_valid_next               = 1'b1;
                    out_data_next.decoded_symbol = pick_sym;
                    out_data_next.status         = pctd_pkg::STATUS_OK;
                end
                else if (pending_len_reg >= pctd_pkg::LEN_W'(pctd_pkg::CODE_LIMIT))
                begin
                    pending_code_next            = '0;
                    pending_len_next             = '0;
                    out_valid_next               = 1'b1;
                    out_data_next.decoded_symbol = '0;
                    out_data_next.status         = pctd_pkg::STATUS_OVERLONG;
                end
            end
            default:
            begin
                state_next = pctd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pick_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pctd_pkg::ST_PICK) |-> !out_valid_reg)
        else $error("result register busy at pick");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_len_reg <= pctd_pkg::LEN_W'(pctd_pkg::CODE_LIMIT))
        else $error("running code exceeds limit");

    a_pick_leaves_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pctd_pkg::ST_PICK) |=>
        (pending_len_reg < pctd_pkg::LEN_W'(pctd_pkg::CODE_LIMIT)))
        else $error("running code at limit survived pick");

    a_error_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status != pctd_pkg::STATUS_OK))
        |-> (out_data_reg.decoded_symbol == '0))
        else $error("error result carries a symbol");

endmodule
`default_nettype wire
